>>> rtl/i2cbe_pkg.sv
package i2cbe_pkg;

    localparam int DATA_BITS = 8;
    localparam int CNT_W     = 8;
    localparam int BITS_W    = 4;
    localparam int REG_W     = 8;
    localparam int ADDR_W    = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // command codes carried by func
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_WRITE    = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;
    localparam logic [2:0] CMD_WAIT_ACK = 3'd5;

    // register indexes (word address)
    localparam logic [1:0] REG_START_STOP = 2'd0;
    localparam logic [1:0] REG_HALF_BIT   = 2'd1;
    localparam logic [1:0] REG_ACK_TMO    = 2'd2;

    localparam logic [REG_W-1:0] RST_START_STOP = 8'd4;
    localparam logic [REG_W-1:0] RST_HALF_BIT   = 8'd2;
    localparam logic [REG_W-1:0] RST_ACK_TMO    = 8'd250;

    typedef struct packed {
        logic [REG_W-1:0] start_stop_ticks;
        logic [REG_W-1:0] half_bit_ticks;
        logic [REG_W-1:0] ack_timeout;
    } t_cfg;

    // one classified tick as it sits in the queue
    typedef struct packed {
        logic [2:0]           cmd;
        logic [DATA_BITS-1:0] tx_byte;
        logic                 send_ack;
        logic                 sda_line;
    } t_tick;

endpackage

>>> rtl/i2cbe_if.sv
interface i2cbe_in_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        func;
    logic [i2cbe_pkg::DATA_BITS-1:0]   tx_byte;
    logic                              send_ack;
    logic                              sda_line;

    modport source (output valid, output func, output tx_byte, output send_ack,
                    output sda_line, input ready);
    modport sink   (input valid, input func, input tx_byte, input send_ack,
                    input sda_line, output ready);
endinterface

interface i2cbe_out_if;
    logic                              valid;
    logic                              ready;
    logic                              scl_level;
    logic                              sda_level;
    logic                              sda_is_output;
    logic                              busy_res;
    logic                              done_res;
    logic [i2cbe_pkg::DATA_BITS-1:0]   rx_byte;
    logic                              ack_missing;

    modport source (output valid, output scl_level, output sda_level,
                    output sda_is_output, output busy_res, output done_res,
                    output rx_byte, output ack_missing, input ready);
    modport sink   (input valid, input scl_level, input sda_level,
                    input sda_is_output, input busy_res, input done_res,
                    input rx_byte, input ack_missing, output ready);
endinterface

>>> rtl/i2cbe_regs.sv
module i2cbe_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [i2cbe_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output i2cbe_pkg::t_cfg             o_cfg
);

    i2cbe_pkg::t_cfg r_cfg;
    logic            wr_en;
    logic [1:0]      idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_stop_ticks <= i2cbe_pkg::RST_START_STOP;
            r_cfg.half_bit_ticks   <= i2cbe_pkg::RST_HALF_BIT;
            r_cfg.ack_timeout      <= i2cbe_pkg::RST_ACK_TMO;
        end else if (wr_en) begin
            case (idx)
                i2cbe_pkg::REG_START_STOP: r_cfg.start_stop_ticks <= pwdata[7:0];
                i2cbe_pkg::REG_HALF_BIT:   r_cfg.half_bit_ticks   <= pwdata[7:0];
                i2cbe_pkg::REG_ACK_TMO:    r_cfg.ack_timeout      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            i2cbe_pkg::REG_START_STOP: prdata = {24'd0, r_cfg.start_stop_ticks};
            i2cbe_pkg::REG_HALF_BIT:   prdata = {24'd0, r_cfg.half_bit_ticks};
            i2cbe_pkg::REG_ACK_TMO:    prdata = {24'd0, r_cfg.ack_timeout};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/i2cbe_front.sv
module i2cbe_front (
    i2cbe_in_if.sink               i_item,
    input  logic                   i_full,
    output logic                   o_push,
    output i2cbe_pkg::t_tick       o_tick
);

    // func codes outside the command set count as no command
    logic cmd_ok;

    assign cmd_ok       = i_item.func inside {[i2cbe_pkg::CMD_START:i2cbe_pkg::CMD_WAIT_ACK]};
    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    always_comb begin
        o_tick.cmd      = cmd_ok ? i_item.func : i2cbe_pkg::CMD_NONE;
        o_tick.tx_byte  = i_item.tx_byte;
        o_tick.send_ack = i_item.send_ack;
        o_tick.sda_line = i_item.sda_line;
    end

endmodule

>>> rtl/i2cbe_fifo.sv
module i2cbe_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  i2cbe_pkg::t_tick       i_tick,
    output logic                   o_full,
    input  logic                   i_pop,
    output logic                   o_valid,
    output i2cbe_pkg::t_tick       o_tick
);

    i2cbe_pkg::t_tick r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_tick  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/i2cbe_engine.sv
module i2cbe_engine (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  i2cbe_pkg::t_cfg        i_cfg,
    input  logic                   i_valid,
    input  i2cbe_pkg::t_tick       i_tick,
    output logic                   o_pop,
    i2cbe_out_if.source            o_res
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ST_A    = 4'd1;
    localparam logic [3:0] PH_ST_B    = 4'd2;
    localparam logic [3:0] PH_SP_A    = 4'd3;
    localparam logic [3:0] PH_SP_B    = 4'd4;
    localparam logic [3:0] PH_W_LOW   = 4'd5;
    localparam logic [3:0] PH_W_HIGH  = 4'd6;
    localparam logic [3:0] PH_W_GAP   = 4'd7;
    localparam logic [3:0] PH_R_LOW   = 4'd8;
    localparam logic [3:0] PH_R_HIGH  = 4'd9;
    localparam logic [3:0] PH_K_LOW   = 4'd10;
    localparam logic [3:0] PH_K_HIGH  = 4'd11;
    localparam logic [3:0] PH_WA_LOW  = 4'd12;
    localparam logic [3:0] PH_WA_HIGH = 4'd13;
    localparam logic [3:0] PH_POLL    = 4'd14;

    localparam int DB = i2cbe_pkg::DATA_BITS;
    localparam int CW = i2cbe_pkg::CNT_W;
    localparam int BW = i2cbe_pkg::BITS_W;
    localparam logic [BW-1:0] LAST_BIT = BW'(DB);

    logic [3:0]    r_phase, n_phase;
    logic [2:0]    r_cmd, n_cmd;
    logic [CW-1:0] r_tick, n_tick;
    logic [BW-1:0] r_bits, n_bits;
    logic [DB-1:0] r_shift, n_shift;
    logic [7:0]    r_poll, n_poll;
    logic          r_ackc, n_ackc;
    logic          r_scl, n_scl;
    logic          r_sda, n_sda;
    logic          r_dir, n_dir;
    logic          r_err, n_err;
    logic [DB-1:0] r_rx, n_rx;
    logic          r_done, n_done;
    logic          r_ovalid;

    logic          take;
    logic [CW-1:0] lim_raw, lim, tick_inc;
    logic          elapsed;
    logic [BW-1:0] bits_inc;

    assign take  = i_valid && (!r_ovalid || o_res.ready);
    assign o_pop = take;

    // phase length for the current phase; zero acts as one
    always_comb begin
        case (r_phase)
            PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B: lim_raw = i_cfg.start_stop_ticks;
            PH_R_HIGH, PH_WA_LOW, PH_WA_HIGH:   lim_raw = {1'b0, i_cfg.half_bit_ticks[7:1]};
            default:                            lim_raw = i_cfg.half_bit_ticks;
        endcase
    end

    assign lim      = (lim_raw == '0) ? CW'(1) : lim_raw;
    assign tick_inc = (r_tick == i2cbe_pkg::CNT_MAX) ? r_tick : r_tick + CW'(1);
    assign elapsed  = (tick_inc >= lim);
    assign bits_inc = r_bits + BW'(1);

    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_tick  = elapsed ? '0 : tick_inc;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_poll  = r_poll;
        n_ackc  = r_ackc;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_dir   = r_dir;
        n_err   = r_err;
        n_rx    = r_rx;
        n_done  = 1'b0;

        case (r_phase)
            PH_IDLE: begin
                n_tick = '0;
                if (i_tick.cmd != i2cbe_pkg::CMD_NONE) begin
                    n_err = 1'b0;
                    n_cmd = i_tick.cmd;
                    case (i_tick.cmd)
                        i2cbe_pkg::CMD_START: begin
                            n_dir   = 1'b1;
                            n_sda   = 1'b1;
                            n_scl   = 1'b1;
                            n_phase = PH_ST_A;
                        end
                        i2cbe_pkg::CMD_STOP: begin
                            n_dir   = 1'b1;
                            n_scl   = 1'b0;
                            n_sda   = 1'b0;
                            n_phase = PH_SP_A;
                        end
                        i2cbe_pkg::CMD_WRITE: begin
                            n_dir   = 1'b1;
                            n_scl   = 1'b0;
                            n_bits  = '0;
                            n_sda   = i_tick.tx_byte[DB-1];
                            n_shift = {i_tick.tx_byte[DB-2:0], 1'b0};
                            n_phase = PH_W_LOW;
                        end
                        i2cbe_pkg::CMD_READ: begin
                            n_dir   = 1'b0;
                            n_scl   = 1'b0;
                            n_shift = '0;
                            n_bits  = '0;
                            n_ackc  = i_tick.send_ack;
                            n_phase = PH_R_LOW;
                        end
                        default: begin
                            n_dir   = 1'b0;
                            n_sda   = 1'b1;
                            n_poll  = '0;
                            n_phase = PH_WA_LOW;
                        end
                    endcase
                end
            end
            PH_ST_A: if (elapsed) begin
                n_sda   = 1'b0;
                n_phase = PH_ST_B;
            end
            PH_ST_B: if (elapsed) begin
                n_scl  = 1'b0;
                n_done = 1'b1;
            end
            PH_SP_A: if (elapsed) begin
                n_scl   = 1'b1;
                n_sda   = 1'b1;
                n_phase = PH_SP_B;
            end
            PH_SP_B: if (elapsed) begin
                if (r_cmd == i2cbe_pkg::CMD_WAIT_ACK) begin
                    n_err = 1'b1;
                end
                n_done = 1'b1;
            end
            PH_W_LOW: if (elapsed) begin
                n_scl   = 1'b1;
                n_phase = PH_W_HIGH;
            end
            PH_W_HIGH: if (elapsed) begin
                n_scl   = 1'b0;
                n_phase = PH_W_GAP;
            end
            PH_W_GAP: if (elapsed) begin
                n_bits = bits_inc;
                if (bits_inc >= LAST_BIT) begin
                    n_done = 1'b1;
                end else begin
                    n_sda   = r_shift[DB-1];
                    n_shift = {r_shift[DB-2:0], 1'b0};
                    n_phase = PH_W_LOW;
                end
            end
            PH_R_LOW: if (elapsed) begin
                // sample on the rising SCL tick
                n_scl   = 1'b1;
                n_shift = {r_shift[DB-2:0], i_tick.sda_line};
                n_phase = PH_R_HIGH;
            end
            PH_R_HIGH: if (elapsed) begin
                n_scl  = 1'b0;
                n_bits = bits_inc;
                if (bits_inc >= LAST_BIT) begin
                    n_rx    = r_shift;
                    n_dir   = 1'b1;
                    n_sda   = !r_ackc;
                    n_phase = PH_K_LOW;
                end else begin
                    n_phase = PH_R_LOW;
                end
            end
            PH_K_LOW: if (elapsed) begin
                n_scl   = 1'b1;
                n_phase = PH_K_HIGH;
            end
            PH_K_HIGH: if (elapsed) begin
                n_scl  = 1'b0;
                n_done = 1'b1;
            end
            PH_WA_LOW: if (elapsed) begin
                n_scl   = 1'b1;
                n_phase = PH_WA_HIGH;
            end
            PH_WA_HIGH: if (elapsed) begin
                n_poll  = '0;
                n_phase = PH_POLL;
            end
            PH_POLL: begin
                n_tick = r_tick;
                if (!i_tick.sda_line) begin
                    n_scl  = 1'b0;
                    n_done = 1'b1;
                end else if (r_poll >= i_cfg.ack_timeout) begin
                    // timeout: run the stop sequence
                    n_dir   = 1'b1;
                    n_scl   = 1'b0;
                    n_sda   = 1'b0;
                    n_tick  = '0;
                    n_phase = PH_SP_A;
                end else begin
                    n_poll = r_poll + 8'd1;
                end
            end
            default: begin
                n_tick  = r_tick;
                n_phase = PH_IDLE;
            end
        endcase

        if (n_done) begin
            n_phase = PH_IDLE;
            n_cmd   = i2cbe_pkg::CMD_NONE;
            n_tick  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cmd    <= i2cbe_pkg::CMD_NONE;
            r_tick   <= '0;
            r_bits   <= '0;
            r_shift  <= '0;
            r_poll   <= '0;
            r_ackc   <= 1'b0;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
            r_dir    <= 1'b1;
            r_err    <= 1'b0;
            r_rx     <= '0;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase;
                r_cmd   <= n_cmd;
                r_tick  <= n_tick;
                r_bits  <= n_bits;
                r_shift <= n_shift;
                r_poll  <= n_poll;
                r_ackc  <= n_ackc;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_dir   <= n_dir;
                r_err   <= n_err;
                r_rx    <= n_rx;
                r_done  <= n_done;
            end
            if (take) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // the result shows the state left by the last executed tick
    assign o_res.valid         = r_ovalid;
    assign o_res.scl_level     = r_scl;
    assign o_res.sda_level     = r_sda;
    assign o_res.sda_is_output = r_dir;
    assign o_res.busy_res      = (r_phase != PH_IDLE);
    assign o_res.done_res      = r_done;
    assign o_res.rx_byte       = r_rx;
    assign o_res.ack_missing   = r_err;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_phase == PH_IDLE))
        else $error("done pulse while a sequence is still running");

    // an acked wait leaves SDA released while idle
    a_sda_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_dir |-> (r_phase == PH_IDLE ||
                    r_phase == PH_R_LOW || r_phase == PH_R_HIGH ||
                    r_phase == PH_WA_LOW || r_phase == PH_WA_HIGH ||
                    r_phase == PH_POLL))
        else $error("SDA released outside a read or ack wait");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= LAST_BIT)
        else $error("bit counter ran past the byte");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> $stable(r_phase) && $stable(r_tick) && $stable(r_rx))
        else $error("engine state moved without a tick");

endmodule

>>> rtl/i2c_master_bit_engine_core.sv
// channel  | dir | handshake     | payload
// ---------+-----+---------------+---------------------------------------------
// i_item   | in  | valid/ready   | func, tx_byte, send_ack, sda_line (one tick)
// o_res    | out | valid/ready   | scl/sda levels, sda dir, busy, done, rx, ack
// apb      | in  | psel/penable  | regs at 0x0, 0x4, 0x8 (8-bit values)
//
// One item in, one result out, at one item per cycle sustained while o_res is ready.
// Each item passes through the two-entry tick queue and then the engine's
// state/result register.
// Reset (i_rst_n, sync, active low) leaves the bus idle: SCL 1, SDA 1 driven.
// A stalled o_res holds the engine; the queue keeps taking items until full.
// Timing is counted in items, so stalls never change the bus sequence.
module i2c_master_bit_engine_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    i2cbe_in_if.sink                     i_item,
    i2cbe_out_if.source                  o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [i2cbe_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    i2cbe_pkg::t_cfg  cfg;
    i2cbe_pkg::t_tick front_tick;
    i2cbe_pkg::t_tick queue_tick;
    logic             push;
    logic             full;
    logic             queue_valid;
    logic             pop;

    // timing registers
    i2cbe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // front: take a tick, fold unknown func codes to no command
    i2cbe_front u_front (
        .i_item (i_item),
        .i_full (full),
        .o_push (push),
        .o_tick (front_tick)
    );

    // short queue decouples input acceptance from result backpressure
    i2cbe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tick  (front_tick),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_tick  (queue_tick)
    );

    // back: phase sequencer, one tick per cycle when the result slot is free
    i2cbe_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (queue_valid),
        .i_tick  (queue_tick),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

>>> verif/i2cbe_tb_pkg.sv
package i2cbe_tb_pkg;

    import i2cbe_pkg::*;

    // func values outside the command set, taken as no command
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_START_SETUP,
        SEQ_START_HOLD,
        SEQ_STOP_SETUP,
        SEQ_STOP_HOLD,
        SEQ_WR_LOW,
        SEQ_WR_HIGH,
        SEQ_WR_GAP,
        SEQ_RD_LOW,
        SEQ_RD_HIGH,
        SEQ_ACK_LOW,
        SEQ_ACK_HIGH,
        SEQ_WA_LOW,
        SEQ_WA_HIGH,
        SEQ_POLL
    } t_seq;

    typedef struct packed {
        logic                 scl;
        logic                 sda;
        logic                 sda_oe;
        logic                 busy;
        logic                 done;
        logic [DATA_BITS-1:0] rx;
        logic                 ack_missing;
    } t_bus_levels;

    class bus_tick_scoreboard;
        logic [REG_W-1:0]     ss_ticks;
        logic [REG_W-1:0]     hb_ticks;
        logic [REG_W-1:0]     ack_tmo;
        t_seq                 seq;
        logic [2:0]           act_cmd;
        logic [CNT_W-1:0]     tick_cnt;
        logic [BITS_W-1:0]    bit_cnt;
        logic [DATA_BITS-1:0] shreg;
        logic [DATA_BITS-1:0] rx_hold;
        logic [7:0]           polls;
        logic                 ack_sel;
        logic                 scl;
        logic                 sda;
        logic                 sda_oe;
        logic                 ack_err;
        t_bus_levels          levels_due[$];
        int unsigned          n_errors;

        function new();
            ss_ticks = RST_START_STOP;
            hb_ticks = RST_HALF_BIT;
            ack_tmo  = RST_ACK_TMO;
            seq      = SEQ_IDLE;
            act_cmd  = CMD_NONE;
            tick_cnt = '0;
            bit_cnt  = '0;
            shreg    = '0;
            rx_hold  = '0;
            polls    = '0;
            ack_sel  = 1'b0;
            scl      = 1'b1;
            sda      = 1'b1;
            sda_oe   = 1'b1;
            ack_err  = 1'b0;
            n_errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [REG_W-1:0] val);
            case (idx)
                REG_START_STOP: ss_ticks = val;
                REG_HALF_BIT:   hb_ticks = val;
                REG_ACK_TMO:    ack_tmo  = val;
                default: ;
            endcase
        endfunction

        function t_seq seq_now();
            return seq;
        endfunction

        function int pending();
            return levels_due.size();
        endfunction

        // one tick of a timed phase; zero length counts as one, counter saturates
        function bit phase_done(logic [REG_W-1:0] len);
            logic [REG_W-1:0] lim;
            lim = (len == '0) ? REG_W'(1) : len;
            if (lim > CNT_MAX) lim = CNT_MAX;
            if (tick_cnt < CNT_MAX) tick_cnt++;
            if (tick_cnt >= lim) begin
                tick_cnt = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void shift_out();
            sda   = shreg[DATA_BITS-1];
            shreg = shreg << 1;
        endfunction

        function void enter_stop();
            sda_oe   = 1'b1;
            scl      = 1'b0;
            sda      = 1'b0;
            tick_cnt = '0;
            seq      = SEQ_STOP_SETUP;
        endfunction

        function void take_command(t_tick it);
            ack_err  = 1'b0;
            act_cmd  = it.cmd;
            tick_cnt = '0;
            case (it.cmd)
                CMD_START: begin
                    sda_oe = 1'b1;
                    sda    = 1'b1;
                    scl    = 1'b1;
                    seq    = SEQ_START_SETUP;
                end
                CMD_STOP: begin
                    enter_stop();
                end
                CMD_WRITE: begin
                    sda_oe  = 1'b1;
                    scl     = 1'b0;
                    shreg   = it.tx_byte;
                    bit_cnt = '0;
                    shift_out();
                    seq     = SEQ_WR_LOW;
                end
                CMD_READ: begin
                    sda_oe  = 1'b0;
                    scl     = 1'b0;
                    shreg   = '0;
                    bit_cnt = '0;
                    ack_sel = it.send_ack;
                    seq     = SEQ_RD_LOW;
                end
                default: begin
                    sda_oe = 1'b0;
                    sda    = 1'b1;
                    polls  = '0;
                    seq    = SEQ_WA_LOW;
                end
            endcase
        endfunction

        function t_bus_levels advance(t_tick it);
            bit          fin;
            t_bus_levels r;
            fin = 1'b0;
            case (seq)
                SEQ_IDLE: begin
                    if (it.cmd >= CMD_START && it.cmd <= CMD_WAIT_ACK) take_command(it);
                end
                SEQ_START_SETUP: begin
                    if (phase_done(ss_ticks)) begin
                        sda = 1'b0;
                        seq = SEQ_START_HOLD;
                    end
                end
                SEQ_START_HOLD: begin
                    if (phase_done(ss_ticks)) begin
                        scl = 1'b0;
                        fin = 1'b1;
                    end
                end
                SEQ_STOP_SETUP: begin
                    if (phase_done(ss_ticks)) begin
                        scl = 1'b1;
                        sda = 1'b1;
                        seq = SEQ_STOP_HOLD;
                    end
                end
                SEQ_STOP_HOLD: begin
                    if (phase_done(ss_ticks)) begin
                        if (act_cmd == CMD_WAIT_ACK) ack_err = 1'b1;
                        fin = 1'b1;
                    end
                end
                SEQ_WR_LOW: begin
                    if (phase_done(hb_ticks)) begin
                        scl = 1'b1;
                        seq = SEQ_WR_HIGH;
                    end
                end
                SEQ_WR_HIGH: begin
                    if (phase_done(hb_ticks)) begin
                        scl = 1'b0;
                        seq = SEQ_WR_GAP;
                    end
                end
                SEQ_WR_GAP: begin
                    if (phase_done(hb_ticks)) begin
                        bit_cnt++;
                        if (bit_cnt >= DATA_BITS) begin
                            fin = 1'b1;
                        end else begin
                            shift_out();
                            seq = SEQ_WR_LOW;
                        end
                    end
                end
                SEQ_RD_LOW: begin
                    if (phase_done(hb_ticks)) begin
                        scl   = 1'b1;
                        shreg = {shreg[DATA_BITS-2:0], it.sda_line};
                        seq   = SEQ_RD_HIGH;
                    end
                end
                SEQ_RD_HIGH: begin
                    if (phase_done(hb_ticks >> 1)) begin
                        scl = 1'b0;
                        bit_cnt++;
                        if (bit_cnt >= DATA_BITS) begin
                            rx_hold = shreg;
                            sda_oe  = 1'b1;
                            sda     = ~ack_sel;
                            seq     = SEQ_ACK_LOW;
                        end else begin
                            seq = SEQ_RD_LOW;
                        end
                    end
                end
                SEQ_ACK_LOW: begin
                    if (phase_done(hb_ticks)) begin
                        scl = 1'b1;
                        seq = SEQ_ACK_HIGH;
                    end
                end
                SEQ_ACK_HIGH: begin
                    if (phase_done(hb_ticks)) begin
                        scl = 1'b0;
                        fin = 1'b1;
                    end
                end
                SEQ_WA_LOW: begin
                    if (phase_done(hb_ticks >> 1)) begin
                        scl = 1'b1;
                        seq = SEQ_WA_HIGH;
                    end
                end
                SEQ_WA_HIGH: begin
                    if (phase_done(hb_ticks >> 1)) begin
                        polls = '0;
                        seq   = SEQ_POLL;
                    end
                end
                SEQ_POLL: begin
                    if (!it.sda_line) begin
                        scl = 1'b0;
                        fin = 1'b1;
                    end else if (polls >= ack_tmo) begin
                        enter_stop();
                    end else begin
                        polls++;
                    end
                end
                default: seq = SEQ_IDLE;
            endcase
            if (fin) begin
                seq      = SEQ_IDLE;
                act_cmd  = CMD_NONE;
                tick_cnt = '0;
            end
            r.scl         = scl;
            r.sda         = sda;
            r.sda_oe      = sda_oe;
            r.busy        = (seq != SEQ_IDLE);
            r.done        = fin;
            r.rx          = rx_hold;
            r.ack_missing = ack_err;
            return r;
        endfunction

        function void note_tick(t_tick it);
            levels_due.push_back(advance(it));
        endfunction

        task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got 0x%0h expected 0x%0h", what, got, want);
            n_errors++;
        endtask

        task check_field(string what, logic [31:0] got, logic [31:0] want);
            if (got !== want) flag_mismatch(what, got, want);
        endtask

        task check_levels(t_bus_levels got);
            t_bus_levels want;
            if (levels_due.size() == 0) begin
                flag_mismatch("result with nothing expected", 32'(got), 32'd0);
            end else begin
                want = levels_due.pop_front();
                check_field("scl_level", 32'(got.scl), 32'(want.scl));
                check_field("sda_level", 32'(got.sda), 32'(want.sda));
                check_field("sda_is_output", 32'(got.sda_oe), 32'(want.sda_oe));
                check_field("busy_res", 32'(got.busy), 32'(want.busy));
                check_field("done_res", 32'(got.done), 32'(want.done));
                check_field("rx_byte", 32'(got.rx), 32'(want.rx));
                check_field("ack_missing", 32'(got.ack_missing), 32'(want.ack_missing));
            end
        endtask
    endclass

endpackage

>>> verif/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import i2cbe_pkg::*;
    import i2cbe_tb_pkg::*;

    // generous ceiling for the run guard
    localparam int CYCLE_LIMIT = 1_000_000;
    // receiver hold-off long enough to fill the input queue many times over
    localparam int HOLD_CYCLES = 300;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    i2cbe_in_if  item_if();
    i2cbe_out_if res_if();

    i2c_master_bit_engine_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bus_tick_scoreboard sb;

    int send_idle_pct = 0;   // chance per cycle that the sender holds back
    int stall_pct     = 0;   // chance per cycle that the receiver stalls
    bit hold_req      = 1'b0;
    int items_in      = 0;
    int cycle_count   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run guard: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Monitor. Both channels are sampled on the rising edge; every accepted
    // tick advances the predictor, every accepted result is checked in order.
    always @(posedge i_clk) begin : mon
        t_tick       it;
        t_bus_levels got;
        if (i_rst_n) begin
            if (item_if.valid && item_if.ready) begin
                it.cmd      = item_if.func;
                it.tx_byte  = item_if.tx_byte;
                it.send_ack = item_if.send_ack;
                it.sda_line = item_if.sda_line;
                sb.note_tick(it);
                items_in++;
            end
            if (res_if.valid && res_if.ready) begin
                got.scl         = res_if.scl_level;
                got.sda         = res_if.sda_level;
                got.sda_oe      = res_if.sda_is_output;
                got.busy        = res_if.busy_res;
                got.done        = res_if.done_res;
                got.rx          = res_if.rx_byte;
                got.ack_missing = res_if.ack_missing;
                sb.check_levels(got);
            end
        end
    end

    // Result sink. Random stalls per the phase setting; a hold request turns
    // into a long hold-off counted here while the sender keeps offering ticks.
    initial begin : sink
        int hold_left;
        hold_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else begin
                res_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one tick and wait for its acceptance. Entered and left on a
    // falling edge; random gaps keep valid low for whole cycles.
    task automatic push_tick(input t_tick it);
        while ($urandom_range(99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid    <= 1'b1;
        item_if.func     <= it.cmd;
        item_if.tx_byte  <= it.tx_byte;
        item_if.send_ack <= it.send_ack;
        item_if.sda_line <= it.sda_line;
        do @(posedge i_clk); while (!(item_if.valid && item_if.ready));
        @(negedge i_clk);
    endtask

    // Background tick: no command, or at the noise_pct chance any func value at
    // all (real commands land on a busy engine and must be ignored).
    function automatic t_tick filler_tick(input int noise_pct);
        t_tick it;
        it.cmd      = ($urandom_range(99) < noise_pct) ? 3'($urandom_range(7)) : CMD_NONE;
        it.tx_byte  = 8'($urandom_range(255));
        it.send_ack = 1'($urandom_range(1));
        it.sda_line = 1'($urandom_range(1));
        return it;
    endfunction

    // One bus sequence: let the engine go idle, issue the command, then feed
    // ticks until the predictor says it is done. While polling for ACK, SDA
    // stays high for ack_after polls and then drops; a negative value never
    // drops it, which forces the timeout and the stop sequence.
    task automatic run_sequence(input logic [2:0] cmd, input logic [7:0] tx,
                                input logic ack, input int ack_after,
                                input int noise_pct);
        t_tick it;
        int    polls;
        polls = 0;
        while (sb.seq_now() != SEQ_IDLE) begin
            it = filler_tick(noise_pct);
            push_tick(it);
        end
        it.cmd      = cmd;
        it.tx_byte  = tx;
        it.send_ack = ack;
        it.sda_line = 1'($urandom_range(1));
        push_tick(it);
        while (sb.seq_now() != SEQ_IDLE) begin
            it = filler_tick(noise_pct);
            if (sb.seq_now() == SEQ_POLL) begin
                it.sda_line = (ack_after >= 0 && polls >= ack_after) ? 1'b0 : 1'b1;
                polls++;
            end
            push_tick(it);
        end
    endtask

    // Stop offering, wait until every outstanding result has been checked,
    // then let the clock run on before returning.
    task automatic drain_all();
        item_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // APB write then read-back; psel stays high across the two transfers.
    task automatic program_reg(input logic [1:0] idx, input logic [REG_W-1:0] val);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= 32'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== 32'(val)) sb.flag_mismatch("register readback", rd, 32'(val));
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [REG_W-1:0] ss, input logic [REG_W-1:0] hb,
                             input logic [REG_W-1:0] tmo, input int idle_pct,
                             input int sink_stall_pct);
        drain_all();
        program_reg(REG_START_STOP, ss);
        program_reg(REG_HALF_BIT, hb);
        program_reg(REG_ACK_TMO, tmo);
        send_idle_pct = idle_pct;
        stall_pct     = sink_stall_pct;
    endtask

    // Random traffic: mostly well-formed commands with random content, a
    // share of reserved/none func values, and noise during busy stretches.
    task automatic random_phase(input int n_ticks, input bit with_hold,
                                input bit with_pause);
        int         base;
        bit         held;
        bit         paused;
        logic [2:0] cmd;
        int         ack_after;
        base   = items_in;
        held   = 1'b0;
        paused = 1'b0;
        while (items_in - base < n_ticks) begin
            if (with_hold && !held && items_in - base > n_ticks / 2) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if (with_pause && !paused && items_in - base > n_ticks / 3) begin
                drain_all();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 85) cmd = 3'($urandom_range(CMD_WAIT_ACK, CMD_START));
            else                         cmd = 3'($urandom_range(7));
            ack_after = ($urandom_range(3) == 0) ? -1 : int'($urandom_range(12));
            run_sequence(cmd, 8'($urandom_range(255)), 1'($urandom_range(1)), ack_after, 8);
        end
    endtask

    initial begin
        sb = new();

        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        item_if.valid    = 1'b0;
        item_if.func     = CMD_NONE;
        item_if.tx_byte  = '0;
        item_if.send_ack = 1'b0;
        item_if.sda_line = 1'b1;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed, reset timing (S=4, H=2, T=250), no idling ---
        run_sequence(CMD_START, 8'h00, 1'b0, 0, 0);
        run_sequence(CMD_WRITE, 8'hFF, 1'b0, 0, 0);
        run_sequence(CMD_WRITE, 8'h00, 1'b0, 0, 0);
        run_sequence(CMD_WRITE, 8'hA5, 1'b1, 0, 0);
        run_sequence(CMD_WAIT_ACK, 8'h00, 1'b0, 0, 0);    // ACK on first poll
        run_sequence(CMD_WAIT_ACK, 8'h00, 1'b0, 3, 0);    // ACK after a few polls
        run_sequence(CMD_READ, 8'h00, 1'b1, 0, 0);        // read, send ACK
        run_sequence(CMD_READ, 8'hFF, 1'b0, 0, 0);        // read, send NACK
        run_sequence(CMD_RSVD6, 8'h12, 1'b1, 0, 0);       // reserved func: no-op
        run_sequence(CMD_RSVD7, 8'h34, 1'b0, 0, 0);
        run_sequence(CMD_NONE, 8'hFF, 1'b1, 0, 0);
        run_sequence(CMD_STOP, 8'h00, 1'b0, 0, 100);      // every busy tick carries a random func value
        run_sequence(CMD_WAIT_ACK, 8'h00, 1'b0, -1, 0);   // full timeout, stop, flag set
        run_sequence(CMD_START, 8'h00, 1'b0, 0, 0);       // new command clears the flag
        run_sequence(CMD_STOP, 8'h00, 1'b0, 0, 0);

        // --- random phases across timings and idling modes ---
        configure(8'd1, 8'd1, 8'd1, 0, 0);                // shortest phases, no idling
        random_phase(90, 1'b0, 1'b0);

        configure(8'd2, 8'd3, 8'd5, 52, 0);               // sender idles, odd half bit
        random_phase(100, 1'b0, 1'b1);

        configure(8'd3, 8'd2, 8'd3, 0, 52);               // receiver stalls, long hold
        random_phase(100, 1'b1, 1'b0);

        configure(8'($urandom_range(4, 1)), 8'($urandom_range(4, 1)),
                  8'($urandom_range(8, 1)), 29, 29);      // both sides idle
        random_phase(100, 1'b0, 1'b0);

        configure(8'd0, 8'd0, 8'd0, 0, 0);                // zero lengths act as one
        random_phase(90, 1'b1, 1'b1);

        // --- longest phase: counter runs to its top value ---
        configure(8'd255, 8'd255, 8'd255, 0, 0);
        run_sequence(CMD_START, 8'h00, 1'b0, 0, 0);

        drain_all();
        repeat (8) @(posedge i_clk);

        if (sb.n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/i2cbe_pkg.sv
rtl/i2cbe_if.sv
rtl/i2cbe_regs.sv
rtl/i2cbe_front.sv
rtl/i2cbe_fifo.sv
rtl/i2cbe_engine.sv
rtl/i2c_master_bit_engine_core.sv
verif/i2cbe_tb_pkg.sv
verif/tb.sv
